FILE: design/floppy_fm_mfm_flux_encoder_defines.svh
// Assertion macros used by the flux encoder interval unit.
`ifndef FLOPPY_FM_MFM_FLUX_ENCODER_DEFINES_SVH
`define FLOPPY_FM_MFM_FLUX_ENCODER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define FMFE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flux encoder check failed");

// The consequent holds in the cycle after the antecedent.
`define FMFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flux encoder check failed");

`endif

FILE: design/fmfe_pkg.sv
// Shared types and constants of the flux encoder.
package fmfe_pkg;

   // Command codes of an input transaction.
   localparam logic [2:0] CMD_SKIP    = 3'd0;
   localparam logic [2:0] CMD_FM      = 3'd1;
   localparam logic [2:0] CMD_FM_IAM  = 3'd2;
   localparam logic [2:0] CMD_FM_AM   = 3'd3;
   localparam logic [2:0] CMD_MFM     = 3'd4;
   localparam logic [2:0] CMD_MFM_IAM = 3'd5;
   localparam logic [2:0] CMD_MFM_AM  = 3'd6;
   localparam logic [2:0] CMD_MOD_MFM = 3'd7;

   // Configuration register indexes.
   localparam logic REG_CELL_PERIOD   = 1'b0;
   localparam logic REG_PRECOMP_SHIFT = 1'b1;

   // Clock patterns and window constants.
   localparam logic [7:0] FM_CLOCK_PLAIN = 8'hff;
   localparam logic [7:0] FM_CLOCK_IAM   = 8'hd7;
   localparam logic [7:0] FM_CLOCK_AM    = 8'hc7;
   localparam logic [5:0] MOD_PATTERN    = 6'h1e;
   localparam logic [5:0] MOD_HIGH_PAIR  = 6'h30;
   localparam logic [2:0] MOD_WINDOW_FULL = 3'd5;
   localparam logic [2:0] MOD_WINDOW_KEEP = 3'd4;
   localparam logic [3:0] MOD_CELLS_LAST = 4'd9;
   localparam logic [7:0] GROW_EMPTY     = 8'hff;
   localparam logic [7:0] GROW_LIMIT     = 8'd254;

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_FM,
      KIND_MFM,
      KIND_MOD
   } kind_type;

   // One classified byte waiting for the back end.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] clock_mask;
      logic       miss_valid;
      logic [2:0] miss_index;
      logic [7:0] data_byte;
      logic       end_of_track;
   } entry_type;

   // One bitcell or final-sample request to the interval unit.
   typedef struct packed {
      logic valid;
      logic final_req;
      logic bit_value;
   } cell_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_FLUSH,
      SEQ_BYTE,
      SEQ_PATTERN,
      SEQ_END_FLUSH,
      SEQ_END_CELL,
      SEQ_END_OUT
   } seq_state_type;

endpackage

FILE: design/fmfe_front.sv
// Front end: accepts input transactions, classifies them and queues them.
module fmfe_front
   import fmfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_track,
   output logic       q_valid,
   input  logic       q_pop,
   output entry_type  q_data
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic       wr_ptr_in, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   entry_type  classed;
   logic       push;

   // Decode the command into an encoding kind and its mark details.
   always_comb begin
      classed              = '0;
      classed.kind         = KIND_SKIP;
      classed.clock_mask   = FM_CLOCK_PLAIN;
      classed.data_byte    = req_data_byte;
      classed.end_of_track = req_end_of_track;
      case (req_command)
         CMD_SKIP: begin
            classed.kind = KIND_SKIP;
         end
         CMD_FM: begin
            classed.kind = KIND_FM;
         end
         CMD_FM_IAM: begin
            classed.kind       = KIND_FM;
            classed.clock_mask = FM_CLOCK_IAM;
         end
         CMD_FM_AM: begin
            classed.kind       = KIND_FM;
            classed.clock_mask = FM_CLOCK_AM;
         end
         CMD_MFM: begin
            classed.kind = KIND_MFM;
         end
         CMD_MFM_IAM: begin
            classed.kind       = KIND_MFM;
            classed.miss_valid = 1'b1;
            classed.miss_index = 3'd4;
         end
         CMD_MFM_AM: begin
            classed.kind       = KIND_MFM;
            classed.miss_valid = 1'b1;
            classed.miss_index = 3'd5;
         end
         CMD_MOD_MFM: begin
            classed.kind = KIND_MOD;
         end
         default: begin
            classed.kind = KIND_SKIP;
         end
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= classed;
      end
   end

endmodule

FILE: design/fmfe_seq.sv
// Back-end sequencer: expands a classified byte into bitcells, at most one per cycle, holding while cell_ready is low.
module fmfe_seq
   import fmfe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   output logic      q_pop,
   input  entry_type q_data,
   output cell_type  bitcell,
   input  logic      cell_ready
);

   seq_state_type state_ff, state_in;
   entry_type     entry_ff, entry_in;
   logic [2:0]    bit_ff, bit_in;
   logic [1:0]    sub_ff, sub_in;
   logic [3:0]    pat_ff, pat_in;
   logic          ldb_ff, ldb_in;
   logic [5:0]    win_ff, win_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          prev_mod_ff, prev_mod_in;

   logic       d;
   logic [2:0] cidx;
   logic [5:0] win_shift;
   logic [2:0] cnt_inc;
   logic       take;
   logic       mfm_clock;

   assign d         = entry_ff.data_byte[3'd7 - bit_ff];
   assign cidx      = cnt_ff - 3'd1;
   assign win_shift = {win_ff[4:0], d};
   assign cnt_inc   = cnt_ff + 3'd1;
   assign take      = bitcell.valid && cell_ready;
   assign mfm_clock = !ldb_ff && !d
                      && !(entry_ff.miss_valid && entry_ff.miss_index == bit_ff);

   // Outputs: the cell offered this cycle and the queue pop.
   always_comb begin
      bitcell = '0;
      q_pop   = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            q_pop = q_valid;
         end
         SEQ_FLUSH, SEQ_END_FLUSH: begin
            if (cnt_ff != 3'd0) begin
               bitcell.valid     = 1'b1;
               bitcell.bit_value = (sub_ff == 2'd0) ? ((win_ff & (6'd3 << cidx)) == 6'd0)
                                                    : win_ff[cidx];
            end
         end
         SEQ_BYTE: begin
            case (entry_ff.kind)
               KIND_FM: begin
                  bitcell.valid = 1'b1;
                  case (sub_ff)
                     2'd0:    bitcell.bit_value = entry_ff.clock_mask[3'd7 - bit_ff];
                     2'd2:    bitcell.bit_value = d;
                     default: bitcell.bit_value = 1'b0;
                  endcase
               end
               KIND_MFM: begin
                  bitcell.valid     = 1'b1;
                  bitcell.bit_value = (sub_ff == 2'd0) ? mfm_clock : d;
               end
               KIND_MOD: begin
                  bitcell.valid     = (sub_ff != 2'd0);
                  bitcell.bit_value = (sub_ff == 2'd1) ? ((win_ff & MOD_HIGH_PAIR) == 6'd0)
                                                       : win_ff[4];
               end
               default: begin
                  bitcell.valid = 1'b0;
               end
            endcase
         end
         SEQ_PATTERN: begin
            bitcell.valid     = 1'b1;
            bitcell.bit_value = (pat_ff == 4'd0) || (pat_ff == 4'd4) || (pat_ff == 4'd8);
         end
         SEQ_END_CELL: begin
            bitcell.valid     = 1'b1;
            bitcell.bit_value = 1'b1;
         end
         SEQ_END_OUT: begin
            bitcell.valid     = 1'b1;
            bitcell.final_req = 1'b1;
         end
         default: begin
            bitcell = '0;
         end
      endcase
   end

   // Next state and working registers.
   always_comb begin
      logic advance;
      advance     = 1'b0;
      state_in    = state_ff;
      entry_in    = entry_ff;
      bit_in      = bit_ff;
      sub_in      = sub_ff;
      pat_in      = pat_ff;
      ldb_in      = ldb_ff;
      win_in      = win_ff;
      cnt_in      = cnt_ff;
      prev_mod_in = prev_mod_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (q_valid) begin
               entry_in = q_data;
               bit_in   = 3'd0;
               sub_in   = 2'd0;
               if (prev_mod_ff && q_data.kind != KIND_MOD) begin
                  state_in = SEQ_FLUSH;
               end else begin
                  state_in = SEQ_BYTE;
               end
               if (q_data.kind == KIND_MOD && !prev_mod_ff) begin
                  win_in = 6'd0;
                  cnt_in = 3'd0;
               end
            end
         end
         SEQ_FLUSH, SEQ_END_FLUSH: begin
            if (cnt_ff == 3'd0) begin
               state_in = (state_ff == SEQ_FLUSH) ? SEQ_BYTE : SEQ_END_CELL;
               sub_in   = 2'd0;
            end else if (take) begin
               if (sub_ff == 2'd0) begin
                  sub_in = 2'd1;
               end else begin
                  sub_in = 2'd0;
                  cnt_in = cidx;
               end
            end
         end
         SEQ_BYTE: begin
            case (entry_ff.kind)
               KIND_FM: begin
                  if (take) begin
                     sub_in  = sub_ff + 2'd1;
                     advance = (sub_ff == 2'd3);
                  end
               end
               KIND_MFM: begin
                  if (take) begin
                     sub_in  = (sub_ff == 2'd0) ? 2'd1 : 2'd0;
                     advance = (sub_ff != 2'd0);
                  end
               end
               KIND_MOD: begin
                  if (sub_ff == 2'd0) begin
                     win_in = win_shift;
                     if (cnt_inc == MOD_WINDOW_FULL) begin
                        if (win_shift == MOD_PATTERN) begin
                           cnt_in   = 3'd0;
                           pat_in   = 4'd0;
                           state_in = SEQ_PATTERN;
                        end else begin
                           cnt_in = cnt_inc;
                           sub_in = 2'd1;
                        end
                     end else begin
                        cnt_in  = cnt_inc;
                        advance = 1'b1;
                     end
                  end else if (take) begin
                     if (sub_ff == 2'd1) begin
                        sub_in = 2'd2;
                     end else begin
                        sub_in  = 2'd0;
                        cnt_in  = MOD_WINDOW_KEEP;
                        advance = 1'b1;
                     end
                  end
               end
               default: begin
                  prev_mod_in = 1'b0;
                  state_in    = entry_ff.end_of_track ? SEQ_END_FLUSH : SEQ_IDLE;
               end
            endcase
         end
         SEQ_PATTERN: begin
            if (take) begin
               pat_in = pat_ff + 4'd1;
               if (pat_ff == MOD_CELLS_LAST) begin
                  state_in = SEQ_BYTE;
                  sub_in   = 2'd0;
                  advance  = 1'b1;
               end
            end
         end
         SEQ_END_CELL: begin
            if (take) begin
               state_in = SEQ_END_OUT;
            end
         end
         SEQ_END_OUT: begin
            if (take) begin
               ldb_in      = 1'b0;
               win_in      = 6'd0;
               cnt_in      = 3'd0;
               prev_mod_in = 1'b0;
               state_in    = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
      // Finishing a data bit moves to the next one or closes the byte.
      if (advance) begin
         ldb_in = d;
         if (bit_ff == 3'd7) begin
            prev_mod_in = (entry_ff.kind == KIND_MOD);
            state_in    = entry_ff.end_of_track ? SEQ_END_FLUSH : SEQ_IDLE;
         end else begin
            bit_in   = bit_ff + 3'd1;
            state_in = SEQ_BYTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SEQ_IDLE;
         ldb_ff      <= 1'b0;
         win_ff      <= 6'd0;
         cnt_ff      <= 3'd0;
         prev_mod_ff <= 1'b0;
         sub_ff      <= 2'd0;
         bit_ff      <= 3'd0;
         pat_ff      <= 4'd0;
      end else begin
         state_ff    <= state_in;
         ldb_ff      <= ldb_in;
         win_ff      <= win_in;
         cnt_ff      <= cnt_in;
         prev_mod_ff <= prev_mod_in;
         sub_ff      <= sub_in;
         bit_ff      <= bit_in;
         pat_ff      <= pat_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: design/fmfe_interval.sv
// Interval unit: measures flux intervals, applies precompensation, forms samples.
`include "floppy_fm_mfm_flux_encoder_defines.svh"
module fmfe_interval
   import fmfe_pkg::*;
#(
   parameter int FRAC_BITS   = 4,
   parameter int SAMPLE_BIAS = 129
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [11:0] cell_period,
   input  logic [7:0]  precomp_shift,
   input  cell_type    bitcell,
   output logic        cell_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_sample,
   output logic        rsp_in_range,
   output logic        rsp_last
);

   localparam int HALF = 1 << (FRAC_BITS - 1);

   logic [7:0]        pending_ff, pending_in;
   logic [7:0]        growing_ff, growing_in;
   logic signed [9:0] shift_ff, shift_in;
   logic              out_valid_ff, out_valid_in;
   logic [6:0]        sample_ff, sample_in;
   logic              in_range_ff, in_range_in;
   logic              last_ff, last_in;

   logic                take;
   logic [7:0]          grow_next;
   logic signed [9:0]   adj;
   logic [19:0]         prod;
   logic signed [23:0]  x, t, r, v;
   logic                v_neg, v_high;

   assign cell_ready = !out_valid_ff || rsp_ready;
   assign take       = bitcell.valid && cell_ready;

   // Interval growth with saturation.
   always_comb begin
      if (growing_ff == GROW_EMPTY) begin
         grow_next = 8'd0;
      end else if (growing_ff < GROW_LIMIT) begin
         grow_next = growing_ff + 8'd1;
      end else begin
         grow_next = growing_ff;
      end
   end

   // Precompensation from the pair of neighboring intervals.
   always_comb begin
      if (pending_ff == 8'd2 && grow_next > 8'd2) begin
         adj = -$signed({2'b00, precomp_shift});
      end else if (pending_ff > 8'd2 && grow_next == 8'd2) begin
         adj = $signed({2'b00, precomp_shift});
      end else begin
         adj = 10'sd0;
      end
   end

   // Length times cell period, shift correction, rounding and bias.
   always_comb begin
      prod = 20'(pending_ff) * 20'(cell_period);
      if (bitcell.final_req) begin
         x = -{{14{shift_ff[9]}}, shift_ff};
      end else begin
         x = $signed({4'b0000, prod}) - {{14{shift_ff[9]}}, shift_ff}
             + {{14{adj[9]}}, adj};
      end
      t = x + 24'(HALF);
      if (t[23]) begin
         r = -((-t) >>> FRAC_BITS);
      end else begin
         r = t >>> FRAC_BITS;
      end
      v      = 24'(SAMPLE_BIAS) - r;
      v_neg  = v[23];
      v_high = !v[23] && (v > 24'sd127);
   end

   // Interval state and output register.
   always_comb begin
      pending_in   = pending_ff;
      growing_in   = growing_ff;
      shift_in     = shift_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      sample_in    = sample_ff;
      in_range_in  = in_range_ff;
      last_in      = last_ff;
      if (take) begin
         if (bitcell.final_req) begin
            out_valid_in = 1'b1;
            last_in      = 1'b1;
            in_range_in  = !(v_neg || v_high);
            sample_in    = v_neg ? 7'd0 : (v_high ? 7'd127 : v[6:0]);
            pending_in   = 8'd0;
            growing_in   = GROW_EMPTY;
            shift_in     = 10'sd0;
         end else if (bitcell.bit_value) begin
            if (pending_ff != 8'd0) begin
               out_valid_in = !(v_neg || v_high);
               last_in      = 1'b0;
               in_range_in  = 1'b1;
               sample_in    = v[6:0];
               shift_in     = adj;
            end
            pending_in = grow_next;
            growing_in = 8'd0;
         end else begin
            growing_in = grow_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 8'd0;
         growing_ff   <= GROW_EMPTY;
         shift_ff     <= 10'sd0;
         out_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         growing_ff   <= growing_in;
         shift_ff     <= shift_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      in_range_ff <= in_range_in;
      last_ff     <= last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sample   = sample_ff;
   assign rsp_in_range = in_range_ff;
   assign rsp_last     = last_ff;

   // Checks.
   `FMFE_ASSERT_NEXT(a_final_clears, clock, reset, take && bitcell.final_req,
      pending_ff == 8'd0 && growing_ff == GROW_EMPTY && shift_ff == 10'sd0)
   `FMFE_ASSERT_SAME(a_range_only_last, clock, reset, out_valid_ff && !last_ff,
      in_range_ff)
   `FMFE_ASSERT_NEXT(a_first_edge_silent, clock, reset,
      take && !bitcell.final_req && pending_ff == 8'd0, !out_valid_ff)

endmodule

FILE: design/floppy_fm_mfm_flux_encoder.sv
// Top level: a transaction carries one track byte with its encoding; the block
// writes out flux interval samples, at most 24 per transaction. A queue of two
// classified bytes sits in front of the bitcell sequencer, which handles one
// bitcell per cycle at most and stalls while a finished sample waits in the
// output register. End of track adds the flush of the window, the final cell
// and the final sample; a byte that ends a modified-MFM run first flushes the
// window.
module floppy_fm_mfm_flux_encoder
   import fmfe_pkg::*;
#(
   parameter int FRAC_BITS   = 4,
   parameter int SAMPLE_BIAS = 129
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_track,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_sample,
   output logic        rsp_in_range,
   output logic        rsp_last
);

   logic [11:0] cell_period_ff, cell_period_in;
   logic [7:0]  precomp_shift_ff, precomp_shift_in;
   logic        q_valid, q_pop, cell_ready;
   entry_type   q_data;
   cell_type    bitcell;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_comb begin
      cell_period_in   = cell_period_ff;
      precomp_shift_in = precomp_shift_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_CELL_PERIOD:   cell_period_in   = csr_data;
            REG_PRECOMP_SHIFT: precomp_shift_in = csr_data[7:0];
            default:           cell_period_in   = cell_period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_period_ff   <= 12'd64;
         precomp_shift_ff <= 8'd16;
      end else begin
         cell_period_ff   <= cell_period_in;
         precomp_shift_ff <= precomp_shift_in;
      end
   end

   fmfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .req_end_of_track (req_end_of_track),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_data           (q_data)
   );

   fmfe_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_data     (q_data),
      .bitcell    (bitcell),
      .cell_ready (cell_ready)
   );

   fmfe_interval #(
      .FRAC_BITS   (FRAC_BITS),
      .SAMPLE_BIAS (SAMPLE_BIAS)
   ) u_interval (
      .clock         (clock),
      .reset         (reset),
      .cell_period   (cell_period_ff),
      .precomp_shift (precomp_shift_ff),
      .bitcell       (bitcell),
      .cell_ready    (cell_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample),
      .rsp_in_range  (rsp_in_range),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: test/flux_encoder_checker.sv
// Checker for the flux encoder: watches the channels, predicts samples and compares them.
`timescale 1ns / 100ps

module flux_encoder_checker
   import fmfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_track,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [6:0]  rsp_sample,
   input  logic        rsp_in_range,
   input  logic        rsp_last,
   output int          fail_count,
   output int          samples_pending
);

   typedef struct packed {
      logic [6:0] sample;
      logic       in_range;
      logic       last;
   } flux_sample_type;

   flux_sample_type expected_samples[$];

   // Register copies.
   logic [11:0] period_q;
   logic [7:0]  precomp_q;

   // Encoder state copies.
   logic [7:0]  pend_len;
   logic [7:0]  grow_len;
   int          prev_adj;
   logic        prev_data;
   logic [5:0]  mod_window;
   logic [2:0]  mod_count;
   logic [2:0]  prev_cmd;

   assign samples_pending = expected_samples.size();

   function automatic int round_to_sample(longint x);
      longint t;
      longint r;
      t = x + (64'sd1 <<< 3);
      if (t >= 0) r = t >>> 4;
      else r = -((-t) >>> 4);
      return 129 - int'(r);
   endfunction

   task automatic clear_encoder();
      pend_len = 8'd0;
      grow_len = GROW_EMPTY;
      prev_adj = 0;
      prev_data = 1'b0;
      mod_window = 6'd0;
      mod_count = 3'd0;
      prev_cmd = CMD_SKIP;
   endtask

   // One bitcell: grow the interval and close it on a transition.
   task automatic push_cell(logic b);
      int  adj;
      longint x;
      int  v;
      flux_sample_type s;
      if (grow_len == GROW_EMPTY) grow_len = 8'd0;
      else if (grow_len < GROW_LIMIT) grow_len++;
      if (b) begin
         if (pend_len > 0) begin
            adj = 0;
            if (pend_len == 2 && grow_len > 2) adj = -int'(precomp_q);
            else if (pend_len > 2 && grow_len == 2) adj = int'(precomp_q);
            x = longint'(pend_len) * longint'(period_q) - prev_adj + adj;
            v = round_to_sample(x);
            if (v >= 0 && v <= 127) begin
               s.sample = v[6:0];
               s.in_range = 1'b1;
               s.last = 1'b0;
               expected_samples.push_back(s);
            end
            prev_adj = adj;
         end
         pend_len = grow_len;
         grow_len = 8'd0;
      end
   endtask

   task automatic flush_window();
      while (mod_count > 0) begin
         mod_count--;
         push_cell((mod_window & (6'd3 << mod_count)) == 0);
         push_cell((mod_window & (6'd1 << mod_count)) != 0);
      end
   endtask

   task automatic shift_mod_bit(logic b);
      mod_window = {mod_window[4:0], b};
      mod_count++;
      if (mod_count == MOD_WINDOW_FULL) begin
         if (mod_window == MOD_PATTERN) begin
            for (int i = 0; i < 10; i++) push_cell(i % 4 == 0);
            mod_count = 3'd0;
         end else begin
            push_cell((mod_window & MOD_HIGH_PAIR) == 0);
            push_cell(mod_window[4]);
            mod_count = MOD_WINDOW_KEEP;
         end
      end
   endtask

   // Expand one accepted byte into expected samples.
   task automatic predict_byte(logic [2:0] cmd, logic [7:0] data, logic eot);
      logic d;
      logic clk_bit;
      longint g;
      int v;
      flux_sample_type s;
      if (prev_cmd == CMD_MOD_MFM && cmd != CMD_MOD_MFM) flush_window();
      if (cmd == CMD_MOD_MFM && prev_cmd != CMD_MOD_MFM) begin
         mod_window = 6'd0;
         mod_count = 3'd0;
      end
      if (cmd != CMD_SKIP) begin
         for (int i = 0; i < 8; i++) begin
            d = data[7 - i];
            case (cmd)
               CMD_FM, CMD_FM_IAM, CMD_FM_AM: begin
                  clk_bit = (cmd == CMD_FM) ? FM_CLOCK_PLAIN[7 - i] :
                            (cmd == CMD_FM_IAM) ? FM_CLOCK_IAM[7 - i] : FM_CLOCK_AM[7 - i];
                  push_cell(clk_bit);
                  push_cell(1'b0);
                  push_cell(d);
                  push_cell(1'b0);
               end
               CMD_MFM, CMD_MFM_IAM, CMD_MFM_AM: begin
                  clk_bit = !prev_data && !d;
                  if ((cmd == CMD_MFM_IAM && i == 4) || (cmd == CMD_MFM_AM && i == 5))
                     clk_bit = 1'b0;
                  push_cell(clk_bit);
                  push_cell(d);
               end
               default: shift_mod_bit(d);
            endcase
            prev_data = d;
         end
      end
      prev_cmd = cmd;
      if (eot) begin
         flush_window();
         push_cell(1'b1);
         g = (grow_len == GROW_EMPTY) ? -1 : longint'(grow_len);
         v = round_to_sample(g * longint'(period_q) - prev_adj);
         s.last = 1'b1;
         s.in_range = 1'b0;
         if (v < 0) s.sample = 7'd0;
         else if (v > 127) s.sample = 7'd127;
         else begin
            s.sample = v[6:0];
            s.in_range = 1'b1;
         end
         expected_samples.push_back(s);
         clear_encoder();
      end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // Observe every transaction at the rising edge.
   always @(posedge clock) begin
      flux_sample_type want;
      if (reset) begin
         period_q = 12'd64;
         precomp_q = 8'd16;
         clear_encoder();
         expected_samples.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_CELL_PERIOD) period_q = csr_data;
            else precomp_q = csr_data[7:0];
         end
         if (req_valid && req_ready)
            predict_byte(req_command, req_data_byte, req_end_of_track);
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected sample", int'(rsp_sample), -1);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample != want.sample)
                  report_mismatch("sample", int'(rsp_sample), int'(want.sample));
               if (rsp_in_range != want.in_range)
                  report_mismatch("in_range", int'(rsp_in_range), int'(want.in_range));
               if (rsp_last != want.last)
                  report_mismatch("last", int'(rsp_last), int'(want.last));
            end
         end
      end
   end

endmodule

FILE: test/tb_floppy_fm_mfm_flux_encoder.sv
// Testbench top for the flux encoder: drives bytes and registers, then gives the verdict.
`timescale 1ns / 100ps

module tb_floppy_fm_mfm_flux_encoder;
   import fmfe_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [11:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_command;
   logic [7:0]  req_data_byte;
   logic        req_end_of_track;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [6:0]  rsp_sample;
   logic        rsp_in_range;
   logic        rsp_last;
   int          fail_count;
   int          samples_pending;
   int          cycle_count = 0;
   bit          long_hold;

   floppy_fm_mfm_flux_encoder uut (.*);

   flux_encoder_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("tb_floppy_fm_mfm_flux_encoder NOT OK");
         $finish;
      end
   end

   // Receiver: random stalls, and one long hold-off when asked.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 15));
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Valid stays high after the transaction until the next gap or the next byte.
   task automatic send_byte(logic [2:0] cmd, logic [7:0] data, logic eot, bit no_gap);
      int gap;
      gap = no_gap ? 0 : int'($urandom_range(0, 15));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_data_byte <= data;
      req_end_of_track <= eot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Wait until every expected sample has come and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      while (samples_pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   // The caller lowers csr_valid after the last write of a group.
   task automatic write_reg(logic idx, logic [11:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // One random byte: mostly plain MFM, modified MFM or FM, sometimes any command.
   task automatic random_byte(bit no_gap);
      logic [2:0] cmd;
      int r;
      r = int'($urandom_range(0, 9));
      if (r < 3) cmd = CMD_MFM;
      else if (r < 5) cmd = CMD_MOD_MFM;
      else if (r < 7) cmd = CMD_FM;
      else cmd = 3'($urandom_range(0, 7));
      send_byte(cmd, 8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0, no_gap);
   endtask

   initial begin
      logic [11:0] periods[5];
      logic [7:0]  shifts[5];
      csr_valid = 1'b0;
      csr_index = REG_CELL_PERIOD;
      csr_data = 12'd0;
      req_valid = 1'b0;
      req_command = CMD_SKIP;
      req_data_byte = 8'd0;
      req_end_of_track = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every command, field extremes, mark clocks, the 011110 pattern.
      send_byte(CMD_SKIP, 8'hff, 1'b0, 1'b0);
      send_byte(CMD_FM, 8'h00, 1'b0, 1'b0);
      send_byte(CMD_FM, 8'hff, 1'b0, 1'b0);
      send_byte(CMD_FM_IAM, 8'hfc, 1'b0, 1'b0);
      send_byte(CMD_FM_AM, 8'hfe, 1'b0, 1'b0);
      send_byte(CMD_MFM, 8'h4e, 1'b0, 1'b0);
      send_byte(CMD_MFM, 8'h00, 1'b0, 1'b0);
      send_byte(CMD_MFM_IAM, 8'hc2, 1'b0, 1'b0);
      send_byte(CMD_MFM_AM, 8'ha1, 1'b0, 1'b0);
      send_byte(CMD_MOD_MFM, 8'h78, 1'b0, 1'b0);
      send_byte(CMD_MOD_MFM, 8'h1e, 1'b0, 1'b0);
      send_byte(CMD_MFM, 8'h55, 1'b0, 1'b0);
      send_byte(CMD_MOD_MFM, 8'hf0, 1'b1, 1'b0);
      send_byte(CMD_SKIP, 8'h00, 1'b1, 1'b0);
      // A run of skip bytes, then zero FM address-mark bytes between MFM bytes.
      for (int i = 0; i < 5; i++) send_byte(CMD_SKIP, 8'h00, 1'b0, 1'b0);
      send_byte(CMD_MFM, 8'h80, 1'b0, 1'b0);
      for (int i = 0; i < 4; i++) send_byte(CMD_FM_AM, 8'h00, 1'b0, 1'b0);
      send_byte(CMD_MFM, 8'h01, 1'b1, 1'b0);

      // Register settings, extremes included, each written with the block idle.
      periods = '{12'd0, 12'd4095, 12'd32, 12'd48, 12'd100};
      shifts = '{8'd0, 8'd255, 8'd40, 8'd8, 8'd16};
      for (int p = 0; p < 5; p++) begin
         drain();
         write_reg(REG_CELL_PERIOD, periods[p]);
         write_reg(REG_PRECOMP_SHIFT, {4'h0, shifts[p]});
         csr_valid <= 1'b0;
         for (int i = 0; i < 24; i++) random_byte(1'b0);
         send_byte(CMD_MFM, 8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end

      // Back-pressure: hold the receiver off while bytes keep coming.
      long_hold = 1'b1;
      for (int i = 0; i < 20; i++) random_byte(1'b1);
      send_byte(CMD_FM, 8'h00, 1'b1, 1'b1);
      drain();

      if (fail_count == 0) begin
         $display("tb_floppy_fm_mfm_flux_encoder OK");
      end else begin
         $display("tb_floppy_fm_mfm_flux_encoder NOT OK");
      end
      $finish;
   end

endmodule

FILE: floppy_fm_mfm_flux_encoder.f
+incdir+design
design/fmfe_pkg.sv
design/fmfe_front.sv
design/fmfe_seq.sv
design/fmfe_interval.sv
design/floppy_fm_mfm_flux_encoder.sv
test/flux_encoder_checker.sv
test/tb_floppy_fm_mfm_flux_encoder.sv
